// ----- rtl/core/pfvs_pkg.sv -----
// pfvs_pkg: shared types and constants of the protobuf varint field scanner
// no dependencies; used by pfvs_parse and protobuf_field_varint_scanner_core

package pfvs_pkg;

  // accumulator keeps only the bits that a tag field number or a 32-bit value can reach
  localparam int unsigned ACC_W = 35;

  // field number width of the wanted-field register
  localparam int unsigned FIELD_W = 29;

  // a varint ends after this many bytes whatever its continuation bit says
  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

  // payload bits carried by each varint byte
  localparam logic [5:0] VARINT_BITS_PER_BYTE = 6'd7;

  // bytes skipped for a fixed32 field
  localparam logic [31:0] FIXED32_BYTES = 32'd4;

  // reset value of the wanted-field register
  localparam logic [FIELD_W-1:0] WANTED_FIELD_RESET = 29'd3;

  // parse phases
  localparam logic [1:0] PH_TAG    = 2'd0;
  localparam logic [1:0] PH_VALUE  = 2'd1;
  localparam logic [1:0] PH_LENLEN = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  // wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // result status codes
  localparam logic [1:0] ST_ABSENT    = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_message;
  } pfvs_in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] field_value;
  } pfvs_out_t;

  // per-message parse state
  typedef struct packed {
    logic [1:0]       phase;
    logic [ACC_W-1:0] acc;
    logic [3:0]       cnt;
    logic [31:0]      skip;
    logic             hit;
    logic             decided;
    logic [1:0]       dec_status;
  } pfvs_state_t;

  // state at the start of every message
  localparam pfvs_state_t STATE_IDLE = '{
    phase:      PH_TAG,
    acc:        '0,
    cnt:        4'd0,
    skip:       32'd0,
    hit:        1'b0,
    decided:    1'b0,
    dec_status: ST_ABSENT
  };

endpackage

// ----- rtl/core/protobuf_field_varint_scanner_core.sv -----
// protobuf_field_varint_scanner_core: top level of the protobuf varint field scanner
// depends on pfvs_pkg and pfvs_parse
//
//   channel  direction  handshake                  payload
//   in_      input      in_valid / in_stall        pfvs_in_t  (byte, last, empty)
//   out_     output     out_valid / out_stall      pfvs_out_t (status, field value)
//   cfg_     input      cfg_wr_en, no handshake    wanted field number, 29 bits
//
// one byte per cycle while out_stall holds no result: an accepted byte sits in the input
// register, is parsed in one pass against the message state and, on a last or empty
// transaction, lands in the result register when it advances out of the input register.
// synchronous active-low reset clears the handshake flags, the message state and
// sets the wanted field to 3.
// a held result under out_stall keeps the input register from parsing, which raises
// in_stall while a transaction waits there

module protobuf_field_varint_scanner_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pfvs_pkg::pfvs_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pfvs_pkg::pfvs_out_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [pfvs_pkg::FIELD_W-1:0]  cfg_wr_data
);

  logic                         in_vld_r;
  logic                         in_vld_nxt;
  pfvs_pkg::pfvs_in_t           in_r;
  pfvs_pkg::pfvs_state_t        st_r;
  pfvs_pkg::pfvs_state_t        st_nxt;
  logic [pfvs_pkg::FIELD_W-1:0] wanted_r;
  logic                         out_vld_r;
  logic                         out_vld_nxt;
  pfvs_pkg::pfvs_out_t          out_r;
  pfvs_pkg::pfvs_out_t          res;
  logic                         res_emit;
  logic                         advance;
  logic                         accept;

  // handshake control
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance && res_emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // byte parser
  pfvs_parse u_parse (
    .st       (st_r),
    .in_item  (in_r),
    .wanted   (wanted_r),
    .st_nxt   (st_nxt),
    .res_emit (res_emit),
    .res      (res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= pfvs_pkg::STATE_IDLE;
      wanted_r  <= pfvs_pkg::WANTED_FIELD_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
      if (cfg_wr_en) begin
        wanted_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (advance && res_emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/pfvs_parse.sv -----
// pfvs_parse: next-state and result logic for one message byte
// depends on pfvs_pkg

module pfvs_parse (
  input  pfvs_pkg::pfvs_state_t            st,
  input  pfvs_pkg::pfvs_in_t               in_item,
  input  logic [pfvs_pkg::FIELD_W-1:0]     wanted,
  output pfvs_pkg::pfvs_state_t            st_nxt,
  output logic                             res_emit,
  output pfvs_pkg::pfvs_out_t              res
);

  logic [pfvs_pkg::ACC_W-1:0] acc_sh;
  logic [pfvs_pkg::ACC_W-1:0] byte_ext;
  logic [3:0]                 cnt_sh;
  logic                       done;
  logic [2:0]                 tag_wire;
  logic [31:0]                tag_field;
  logic [31:0]                skip_dec;
  pfvs_pkg::pfvs_state_t      n;

  // varint shift-in of the current byte
  always_comb begin
    byte_ext = {{(pfvs_pkg::ACC_W-7){1'b0}}, in_item.data_byte[6:0]};
    if (st.cnt < pfvs_pkg::VARINT_MAX_BYTES) begin
      acc_sh = st.acc | (byte_ext << (6'(st.cnt) * pfvs_pkg::VARINT_BITS_PER_BYTE));
      cnt_sh = st.cnt + 4'd1;
    end else begin
      acc_sh = st.acc;
      cnt_sh = st.cnt;
    end
    done      = !in_item.data_byte[7] || (cnt_sh >= pfvs_pkg::VARINT_MAX_BYTES);
    tag_wire  = acc_sh[2:0];
    tag_field = acc_sh[pfvs_pkg::ACC_W-1:3];
    skip_dec  = (st.skip != 32'd0) ? st.skip - 32'd1 : st.skip;
  end

  // phase step, then end-of-message result
  always_comb begin
    n        = st;
    res_emit = 1'b0;
    res      = '{status: pfvs_pkg::ST_ABSENT, field_value: 32'd0};
    if (in_item.empty_message) begin
      n        = pfvs_pkg::STATE_IDLE;
      res_emit = 1'b1;
    end else begin
      if (!st.decided) begin
        unique case (st.phase)
          pfvs_pkg::PH_TAG: begin
            n.acc = acc_sh;
            n.cnt = cnt_sh;
            if (done || in_item.last_byte) begin
              n.acc = '0;
              n.cnt = 4'd0;
              priority if (tag_wire == pfvs_pkg::WT_VARINT) begin
                n.hit   = (tag_field == {3'b000, wanted});
                n.phase = pfvs_pkg::PH_VALUE;
              end else if (tag_wire == pfvs_pkg::WT_LEN) begin
                n.phase = pfvs_pkg::PH_LENLEN;
              end else if (tag_wire == pfvs_pkg::WT_FIXED32) begin
                n.skip  = pfvs_pkg::FIXED32_BYTES;
                n.phase = pfvs_pkg::PH_SKIP;
              end else begin
                n.decided    = 1'b1;
                n.dec_status = pfvs_pkg::ST_MALFORMED;
              end
            end
          end
          pfvs_pkg::PH_VALUE: begin
            n.acc = acc_sh;
            n.cnt = cnt_sh;
            if (done) begin
              if (st.hit) begin
                n.decided    = 1'b1;
                n.dec_status = pfvs_pkg::ST_FOUND;
                n.acc        = {3'b000, acc_sh[31:0]};
              end else begin
                n.phase = pfvs_pkg::PH_TAG;
                n.acc   = '0;
                n.cnt   = 4'd0;
              end
            end
          end
          pfvs_pkg::PH_LENLEN: begin
            n.acc = acc_sh;
            n.cnt = cnt_sh;
            if (done) begin
              n.acc = '0;
              n.cnt = 4'd0;
              if (acc_sh[31:0] == 32'd0) begin
                n.phase = pfvs_pkg::PH_TAG;
              end else begin
                n.skip  = acc_sh[31:0];
                n.phase = pfvs_pkg::PH_SKIP;
              end
            end
          end
          pfvs_pkg::PH_SKIP: begin
            n.skip = skip_dec;
            if (skip_dec == 32'd0) begin
              n.phase = pfvs_pkg::PH_TAG;
              n.acc   = '0;
              n.cnt   = 4'd0;
            end
          end
          default: begin
            n = st;
          end
        endcase
      end
      // last byte closes the message
      if (in_item.last_byte) begin
        res_emit = 1'b1;
        if (n.decided) begin
          res.status      = n.dec_status;
          res.field_value = n.acc[31:0];
        end else if ((n.phase == pfvs_pkg::PH_VALUE) && n.hit) begin
          res.status      = pfvs_pkg::ST_FOUND;
          res.field_value = n.acc[31:0];
        end
        n = pfvs_pkg::STATE_IDLE;
      end
    end
    st_nxt = n;
  end

endmodule
